FILE: src/elaf_pkg.sv
// Package with the shared types and constants of the encoder level average filter.
`default_nettype none

package elaf_pkg;

    localparam int AVG_LEN  = 10;
    localparam int LEVEL_W  = 10;
    localparam int TIME_W   = 32;
    localparam int DEB_W    = 8;
    localparam int POS_W    = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
    localparam int SUM_W    = $clog2(AVG_LEN * ((1 << LEVEL_W) - 1) + 1);

    // Exact floor division by AVG_LEN for any sum below 2**SUM_W.
    localparam int DIV_SHIFT = SUM_W + $clog2(AVG_LEN);
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + AVG_LEN - 1) / AVG_LEN;
    localparam int MULT_W    = $clog2(DIV_MULT + 1);
    localparam int PROD_W    = SUM_W + MULT_W;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET  = DEB_W'(10);
    localparam logic [LEVEL_W-1:0] LEVEL_MIN_RESET = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX_RESET = LEVEL_W'(100);
    localparam logic [LEVEL_W-1:0] LEVEL_RESET     = LEVEL_W'(1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEVEL_W;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAX = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              dir_level;
    } evt_t;

    typedef struct packed {
        logic               accepted;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] mean_level;
        logic               changed;
    } res_t;

    typedef struct packed {
        logic [DEB_W-1:0]   debounce_ms;
        logic [LEVEL_W-1:0] level_min;
        logic [LEVEL_W-1:0] level_max;
    } cfg_t;

    typedef struct packed {
        logic               accepted;
        logic [LEVEL_W-1:0] level;
        logic [SUM_W-1:0]   sum;
    } mid_t;

endpackage

`default_nettype wire

FILE: src/elaf_step.sv
// Debounce, saturating level step, ring buffer and running sum of the filter.
`default_nettype none

module elaf_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire elaf_pkg::evt_t evt_in,
    input  wire elaf_pkg::cfg_t cfg,
    output elaf_pkg::mid_t     mid
);

    logic [elaf_pkg::TIME_W-1:0]  last_time_reg, last_time_next;
    logic [elaf_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [elaf_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [elaf_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [elaf_pkg::LEVEL_W-1:0] hist_reg [elaf_pkg::AVG_LEN];
    elaf_pkg::mid_t               mid_reg, mid_next;

    logic [elaf_pkg::TIME_W-1:0]  delta;
    logic                         pass;

    assign delta = evt_in.now_ms - last_time_reg;
    assign pass  = delta >= {{(elaf_pkg::TIME_W - elaf_pkg::DEB_W){1'b0}}, cfg.debounce_ms};

    always_comb
    begin
        last_time_next = last_time_reg;
        level_next     = level_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        if (pass)
        begin
            last_time_next = evt_in.now_ms;
            if (!evt_in.dir_level)
            begin
                if (level_reg > cfg.level_min)
                begin
                    level_next = level_reg - 1'b1;
                end
            end
            else
            begin
                if (level_reg < cfg.level_max)
                begin
                    level_next = level_reg + 1'b1;
                end
            end
            sum_next = sum_reg - elaf_pkg::SUM_W'(hist_reg[pos_reg])
                     + elaf_pkg::SUM_W'(level_next);
            if (pos_reg == elaf_pkg::POS_W'(elaf_pkg::AVG_LEN - 1))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        mid_next.accepted = pass;
        mid_next.level    = level_next;
        mid_next.sum      = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            level_reg     <= elaf_pkg::LEVEL_RESET;
            pos_reg       <= '0;
            sum_reg       <= '0;
            for (int i = 0; i < elaf_pkg::AVG_LEN; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            last_time_reg <= last_time_next;
            level_reg     <= level_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            if (pass)
            begin
                hist_reg[pos_reg] <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

`default_nettype wire

FILE: src/elaf_mean.sv
// Mean by reciprocal multiplication, change detection and the result register.
`default_nettype none

module elaf_mean (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire elaf_pkg::mid_t mid,
    output elaf_pkg::res_t      res
);

    logic [elaf_pkg::PROD_W-1:0]  prod;
    logic [elaf_pkg::LEVEL_W-1:0] mean;
    logic                         chg;

    // The reported flag stands in for the "nothing reported yet" reset mark.
    logic                         reported_reg, reported_next;
    logic [elaf_pkg::LEVEL_W-1:0] last_mean_reg, last_mean_next;
    elaf_pkg::res_t               res_reg, res_next;

    assign prod = elaf_pkg::PROD_W'(mid.sum) * elaf_pkg::PROD_W'(elaf_pkg::DIV_MULT);
    assign mean = prod[elaf_pkg::DIV_SHIFT +: elaf_pkg::LEVEL_W];
    assign chg  = mid.accepted && (!reported_reg || (mean != last_mean_reg));

    always_comb
    begin
        reported_next  = reported_reg;
        last_mean_next = last_mean_reg;
        if (chg)
        begin
            reported_next  = 1'b1;
            last_mean_next = mean;
        end
        res_next.accepted   = mid.accepted;
        res_next.level      = mid.level;
        res_next.mean_level = mean;
        res_next.changed    = chg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= 1'b0;
        end
        else if (fire)
        begin
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            last_mean_reg <= last_mean_next;
            res_reg       <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: src/encoder_level_average_filter.sv
// Top level of the encoder level average filter: handshakes, configuration and pipeline control.
// A transaction moves through the input, step stage and result registers in turn.
// Throughput: one transaction per cycle while results are taken; the debounce, level and
// running sum stage carries its state from one transaction to the next.
// The mean stage divides by a constant reciprocal multiply and compares with the last mean.
// Reset (rst_n, asynchronous, active low) empties the pipeline, loads the register
// defaults and clears the ring buffer, the running sum and the reported flag.
`default_nettype none

module encoder_level_average_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              evt_valid,
    output logic                                   evt_ready,
    input  wire elaf_pkg::evt_t                    evt,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output elaf_pkg::res_t                         res,
    input  wire logic                              cfg_we,
    input  wire logic [elaf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [elaf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Configuration registers. Writes to indexes past the list are dropped.
    elaf_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms <= elaf_pkg::DEBOUNCE_RESET;
            cfg_reg.level_min   <= elaf_pkg::LEVEL_MIN_RESET;
            cfg_reg.level_max   <= elaf_pkg::LEVEL_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                elaf_pkg::CFG_DEBOUNCE:  cfg_reg.debounce_ms <= cfg_wdata[elaf_pkg::DEB_W-1:0];
                elaf_pkg::CFG_LEVEL_MIN: cfg_reg.level_min   <= cfg_wdata;
                elaf_pkg::CFG_LEVEL_MAX: cfg_reg.level_max   <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // Three stages: input register, step stage register and result register.
    // Each stage moves on whenever the stage after it is empty or moving.
    logic           in_valid_reg;
    logic           mid_valid_reg;
    logic           out_valid_reg;
    elaf_pkg::evt_t in_data_reg;
    elaf_pkg::mid_t mid;

    logic out_adv;
    logic mid_adv;
    logic in_fire;
    logic step_fire;
    logic mean_fire;

    assign out_adv   = !out_valid_reg || res_ready;
    assign mid_adv   = !mid_valid_reg || out_adv;
    assign evt_ready = !in_valid_reg || mid_adv;
    assign in_fire   = evt_valid && evt_ready;
    assign step_fire = in_valid_reg && mid_adv;
    assign mean_fire = mid_valid_reg && out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt_ready)
            begin
                in_valid_reg <= evt_valid;
            end
            if (mid_adv)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_data_reg <= evt;
        end
    end

    // Step stage: state advances once per transaction, strictly in arrival order.
    elaf_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (step_fire),
        .evt_in (in_data_reg),
        .cfg    (cfg_reg),
        .mid    (mid)
    );

    // Mean stage: owns the last reported mean and the result register.
    elaf_mean u_mean (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (mean_fire),
        .mid   (mid),
        .res   (res)
    );

    assign res_valid = out_valid_reg;

    // The input side stalls only when every stage is full and the result is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !evt_ready |-> (in_valid_reg && mid_valid_reg && out_valid_reg && !res_ready))
        else $error("input stalled with room in the pipeline");

    // A change of mean is only ever reported for an edge that passed debounce.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.changed) |-> res.accepted)
        else $error("change reported for a rejected edge");

    // A held input stage keeps its transaction until the step stage takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !mid_adv) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input stage lost or altered a held transaction");

    // A stalled step stage must not advance the filter state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && !out_adv) |=> (mid_valid_reg && $stable(mid)))
        else $error("step stage changed while stalled");

endmodule

`default_nettype wire

FILE: sim/elaf_report_checker.sv
// Checker that predicts and compares every report of the encoder level average filter.

module elaf_report_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              evt_valid,
    input  wire logic                              evt_ready,
    input  wire elaf_pkg::evt_t                    evt,
    input  wire logic                              res_valid,
    input  wire logic                              res_ready,
    input  wire elaf_pkg::res_t                    res,
    input  wire logic                              cfg_we,
    input  wire logic [elaf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [elaf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                                     waiting,
    output int                                     fail_count,
    output int                                     result_count,
    output int                                     accepted_count,
    output int                                     changed_count
);

    import elaf_pkg::*;

    // Shadow of the filter state and of its registers.
    logic [TIME_W-1:0]  last_stamp;
    logic [LEVEL_W-1:0] level_now;
    logic [LEVEL_W-1:0] ring [AVG_LEN];
    int unsigned        ring_pos;
    logic [SUM_W-1:0]   ring_sum;
    logic [15:0]        reported_mean;
    logic [DEB_W-1:0]   gap_ms;
    logic [LEVEL_W-1:0] floor_level;
    logic [LEVEL_W-1:0] ceil_level;

    res_t reports_due [$];
    res_t want;

    // Applies one encoder edge to the shadow state and returns the report it causes.
    function automatic res_t step_encoder_level(input evt_t e);
        res_t               r;
        logic [TIME_W-1:0]  since;
        logic [LEVEL_W-1:0] avg;
        r     = '0;
        since = e.now_ms - last_stamp;
        if (since >= TIME_W'(gap_ms))
        begin
            r.accepted = 1'b1;
            last_stamp = e.now_ms;
            if (!e.dir_level)
            begin
                if (level_now > floor_level)
                    level_now = level_now - 1'b1;
            end
            else if (level_now < ceil_level)
            begin
                level_now = level_now + 1'b1;
            end
            ring_sum       = ring_sum - SUM_W'(ring[ring_pos]) + SUM_W'(level_now);
            ring[ring_pos] = level_now;
            ring_pos       = (ring_pos == AVG_LEN - 1) ? 0 : ring_pos + 1;
        end
        avg = LEVEL_W'(ring_sum / AVG_LEN);
        if (r.accepted && 16'(avg) != reported_mean)
        begin
            reported_mean = 16'(avg);
            r.changed     = 1'b1;
        end
        r.level      = level_now;
        r.mean_level = avg;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
        if (actual !== expected)
        begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, expected, actual);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp    = '0;
            level_now     = LEVEL_RESET;
            foreach (ring[i])
                ring[i] = '0;
            ring_pos      = 0;
            ring_sum      = '0;
            reported_mean = 16'hFFFF;
            gap_ms        = DEBOUNCE_RESET;
            floor_level   = LEVEL_MIN_RESET;
            ceil_level    = LEVEL_MAX_RESET;
            reports_due.delete();
            fail_count     = 0;
            result_count   = 0;
            accepted_count = 0;
            changed_count  = 0;
            waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE:  gap_ms      = cfg_wdata[DEB_W-1:0];
                    CFG_LEVEL_MIN: floor_level = cfg_wdata[LEVEL_W-1:0];
                    CFG_LEVEL_MAX: ceil_level  = cfg_wdata[LEVEL_W-1:0];
                    default:       ;
                endcase
            end
            if (evt_valid && evt_ready)
                reports_due.push_back(step_encoder_level(evt));
            if (res_valid && res_ready)
            begin
                result_count++;
                if (reports_due.size() == 0)
                begin
                    fail_count++;
                    $error("report arrived with no transaction waiting for it");
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(res.accepted));
                    check_field("level", 32'(want.level), 32'(res.level));
                    check_field("mean_level", 32'(want.mean_level), 32'(res.mean_level));
                    check_field("changed", 32'(want.changed), 32'(res.changed));
                    if (want.accepted)
                        accepted_count++;
                    if (want.changed)
                        changed_count++;
                end
            end
            waiting <= reports_due.size();
        end
    end

endmodule

FILE: sim/tb_encoder_level_average_filter.sv
// Testbench top of the encoder level average filter: stimulus, idling and the verdict.

module tb_encoder_level_average_filter;

    import elaf_pkg::*;

    // Register index past the end of the list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Long receiver hold-off, in cycles, used to back the pipeline up into the input.
    localparam int HOLD_CYCLES = 400;
    // Cycles allowed after the last report.
    localparam int DRAIN_CYCLES = 8;
    // Random transactions per register setting.
    localparam int PHASE_ITEMS = 190;
    // Hard stop for the run, in time units (clock period is 2).
    localparam int RUN_LIMIT = 400000;

    logic                    clk;
    logic                    rst_n;
    logic                    evt_valid;
    logic                    evt_ready;
    evt_t                    evt;
    logic                    res_valid;
    logic                    res_ready;
    res_t                    res;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    int waiting;
    int fail_count;
    int result_count;
    int accepted_count;
    int changed_count;

    // Idle rates of both sides, in percent, and the request for a long output stall.
    int tx_idle_pct = 12;
    int rx_idle_pct = 66;
    bit rx_hold     = 1'b0;

    // The testbench keeps its own copy of the debounce interval and of the time of the
    // last edge that got past it, so that random timestamps can be placed right around
    // the debounce boundary instead of landing far away from it.
    logic [DEB_W-1:0]  gap_shadow;
    logic [TIME_W-1:0] anchor;
    int                settings_used = 0;

    encoder_level_average_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    elaf_report_checker u_report_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt_valid      (evt_valid),
        .evt_ready      (evt_ready),
        .evt            (evt),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .waiting        (waiting),
        .fail_count     (fail_count),
        .result_count   (result_count),
        .accepted_count (accepted_count),
        .changed_count  (changed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver side. Ready is redrawn every cycle from the current idle rate. When a
    // long stall is requested, ready drops for a fixed stretch counted here, which lets
    // the pipeline fill and forces the block to refuse input transactions.
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            else
            begin
                res_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offers one encoder edge and returns at the clock edge where it is accepted.
    // Valid only drops when the sender decides to idle, so back-to-back transactions
    // keep valid high and just change the payload.
    task automatic send_edge(input logic [TIME_W-1:0] stamp, input logic dir);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            evt_valid <= 1'b0;
            @(posedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= '{now_ms: stamp, dir_level: dir};
        if (stamp - anchor >= TIME_W'(gap_shadow))
            anchor = stamp;
        do
            @(posedge clk);
        while (!evt_ready);
    endtask

    // Random edges. Most timestamps sit just past the debounce interval, inside it, or
    // a little later; the rest are fully random stamps that exercise every bit and wrap.
    task automatic run_edges(input int count, input int up_pct);
        logic [TIME_W-1:0] stamp;
        int unsigned       pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                stamp = anchor + gap_shadow + $urandom_range(3);
            else if (pick < 60)
                stamp = anchor + ((gap_shadow == 0) ? 0 : $urandom_range(gap_shadow - 1));
            else if (pick < 85)
                stamp = anchor + gap_shadow + $urandom_range(2000);
            else
                stamp = $urandom;
            send_edge(stamp, $urandom_range(99) < up_pct);
        end
    endtask

    // Stops offering input and waits until every predicted report has been received.
    task automatic drain();
        evt_valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
    endtask

    // Writes all three registers and the spare index, one per cycle. The debounce word
    // carries random bits above its eight bits, which the block must drop.
    task automatic apply_setting(input logic [DEB_W-1:0] deb,
                                 input logic [LEVEL_W-1:0] lo, hi);
        logic [CFG_DATA_W-1:0] word;
        word            = CFG_DATA_W'($urandom);
        word[DEB_W-1:0] = deb;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_wdata <= word;
        @(posedge clk);
        cfg_index <= CFG_LEVEL_MIN;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_index <= CFG_LEVEL_MAX;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        gap_shadow = deb;
        settings_used++;
    endtask

    initial
    begin
        logic [DEB_W-1:0]   deb;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;

        rst_n      = 1'b0;
        evt_valid  = 1'b0;
        evt        = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_DEBOUNCE;
        cfg_wdata  = '0;
        gap_shadow = DEBOUNCE_RESET;
        anchor     = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        settings_used = 1;

        // Directed edges with the reset register values (debounce 10, limits 0 to 100).
        // The last accepted time starts at zero, so the edges stamped 0 and 9 are too early.
        send_edge(32'd0, 1'b1);
        send_edge(32'd9, 1'b0);
        // Exactly one debounce interval: the first accepted edge, which always reports.
        send_edge(32'd10, 1'b1);
        send_edge(32'd10, 1'b1);
        // Step down to the floor and push against it.
        send_edge(32'd20, 1'b0);
        send_edge(32'd30, 1'b0);
        send_edge(32'd45, 1'b0);
        send_edge(32'd54, 1'b1);
        send_edge(32'd60, 1'b1);
        send_edge(32'd70, 1'b1);
        send_edge(32'h5555_5555, 1'b1);
        send_edge(32'hAAAA_AAAA, 1'b0);
        // Debounce measured across the 32-bit wrap of the timestamp.
        send_edge(32'hFFFF_FFF0, 1'b1);
        send_edge(32'hFFFF_FFFF, 1'b1);
        send_edge(32'd8, 1'b1);
        send_edge(32'd9, 1'b1);
        send_edge(32'h8000_0000, 1'b0);
        send_edge(32'h7FFF_FFFF, 1'b1);

        // No debounce and a ceiling below the current level: repeated stamps all pass,
        // steps up are blocked and steps down bring the level back down to the ceiling.
        drain();
        apply_setting(8'd0, 10'd0, 10'd2);
        send_edge(32'd100, 1'b1);
        send_edge(32'd100, 1'b1);
        send_edge(32'd100, 1'b0);
        send_edge(32'd100, 1'b0);
        send_edge(32'd100, 1'b0);
        send_edge(32'd100, 1'b1);

        // Widest limits, no debounce, mostly climbing.
        drain();
        apply_setting(8'd0, 10'd0, 10'd1023);
        run_edges(PHASE_ITEMS, 80);

        // Longest debounce, both limits at the top: the level sits under the floor and
        // can only climb toward it.
        drain();
        apply_setting(8'd255, 10'd1023, 10'd1023);
        run_edges(PHASE_ITEMS, 50);

        // Now the sender idles often and the receiver rarely.
        tx_idle_pct = 66;
        rx_idle_pct = 12;

        // Floor above ceiling. The receiver is held off for a long stretch at the start
        // while the sender keeps offering, so the block has to stall its input.
        drain();
        apply_setting(8'd3, 10'd500, 10'd20);
        rx_hold = 1'b1;
        run_edges(PHASE_ITEMS, 50);

        // A narrow random window near the bottom; half way through the sender waits
        // until every report is back before it carries on.
        drain();
        deb = DEB_W'($urandom_range(20));
        lo  = LEVEL_W'($urandom_range(40));
        hi  = LEVEL_W'($urandom_range(120, lo));
        apply_setting(deb, lo, hi);
        run_edges(PHASE_ITEMS / 2, 50);
        drain();
        run_edges(PHASE_ITEMS - PHASE_ITEMS / 2, 50);

        // Neither side idles from here on.
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        // Smallest nonzero debounce with both limits at zero.
        drain();
        apply_setting(8'd1, 10'd0, 10'd0);
        run_edges(PHASE_ITEMS, 30);

        // Fully random register values.
        drain();
        apply_setting(DEB_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom));
        run_edges(PHASE_ITEMS, 50);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d reports: %0d accepted edges, %0d mean changes.",
                 result_count, accepted_count, changed_count);
        $display("Ran %0d register settings with idle, long output stall and drain pauses.",
                 settings_used);
        if (fail_count == 0 && waiting == 0)
            $display("tb_encoder_level_average_filter: PASS");
        else
            $display("tb_encoder_level_average_filter: FAIL");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(RUN_LIMIT);
        $display("tb_encoder_level_average_filter: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/elaf_pkg.sv
src/elaf_step.sv
src/elaf_mean.sv
src/encoder_level_average_filter.sv
sim/elaf_report_checker.sv
sim/tb_encoder_level_average_filter.sv
